// ----- hdl/assert_macros.svh -----
// assertion macros shared by the allocator rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication on the rising edge of clk, off during reset
`define CCA_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication on the rising edge of clk, off during reset
`define CCA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/cca_pkg.sv -----
// types and fixed constants of the chunk and connection allocator
package cca_pkg;

    // fixed field widths
    localparam int OFF_W   = 40;
    localparam int LEN_W   = 22;
    localparam int CNT_W   = 10;
    localparam int PEER_W  = 3;
    localparam int PCNT_W  = 4;
    localparam int SEGB_W  = 28;
    localparam int ADDR_W  = 6;
    localparam int DATA_W  = 64;

    // peer port spans eight peers
    localparam int PEER_SPACE = 8;

    // bitmap rows: 64 chunks per row
    localparam int ROW_W  = 64;
    localparam int ROW_BW = 6;

    // chunk index carried with a word, wide enough for the largest chunk count
    localparam int IDX_W = 10;

    typedef enum logic [1:0] {
        CMD_BEGIN = 2'd0,
        CMD_GET   = 2'd1,
        CMD_PUT   = 2'd2,
        CMD_ABORT = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_NO_CHUNK   = 3'd1,
        ST_NO_PEER    = 3'd2,
        ST_BAD_OFFSET = 3'd3,
        ST_PEER_IDLE  = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        REG_MAX_CONN  = 3'd0,
        REG_MAX_PEER  = 3'd1,
        REG_PEER_CNT  = 3'd2,
        REG_SEG_BASE  = 3'd3,
        REG_SEG_BYTES = 3'd4
    } reg_idx_t;

    // configuration seen by the datapath
    typedef struct packed {
        logic [CNT_W-1:0]  conn_limit;
        logic [CNT_W-1:0]  max_per_peer;
        logic [PCNT_W-1:0] peer_count;
        logic [OFF_W-1:0]  seg_base;
        logic [SEGB_W-1:0] seg_bytes;
    } cfg_t;

    // classified command word held in the queue
    typedef struct packed {
        cmd_t              cmd;
        logic [PEER_W-1:0] peer;
        logic              bad_off;
        logic [IDX_W-1:0]  idx;
    } item_t;

endpackage

// ----- hdl/cca_front.sv -----
// front end: accepts command words and classifies the chunk offset
module cca_front import cca_pkg::*; #(
    parameter int CHUNK_SHIFT = 21,
    parameter int CNW         = 7
) (
    input  logic              start,
    input  logic [1:0]        cmd,
    input  logic [PEER_W-1:0] peer,
    input  logic [OFF_W-1:0]  chunk_offset,
    input  logic [OFF_W-1:0]  seg_base,
    input  logic [CNW-1:0]    n_chunks,
    input  logic              q_full,
    output logic              busy,
    output logic              push,
    output item_t             item
);

    logic [OFF_W:0]   diff;
    logic [OFF_W-1:0] idx_full;

    // handshake: hold off while the queue is full
    assign busy = q_full;
    assign push = start && !q_full;

    // offset relative to the segment and its chunk index
    assign diff     = {1'b0, chunk_offset} - {1'b0, seg_base};
    assign idx_full = diff[OFF_W-1:0] >> CHUNK_SHIFT;

    // word for the queue
    assign item.cmd     = cmd_t'(cmd);
    assign item.peer    = peer;
    assign item.bad_off = diff[OFF_W] || (idx_full >= OFF_W'(n_chunks));
    assign item.idx     = IDX_W'(idx_full);

endmodule

// ----- hdl/cca_queue.sv -----
// two-entry queue between front end and back end
module cca_queue import cca_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t item_in,
    input  logic  pop,
    output item_t item_out,
    output logic  valid,
    output logic  full
);

    item_t      slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    assign valid    = count_reg != 2'd0;
    assign full     = count_reg == 2'd2;
    assign item_out = slot_reg[rd_ptr_reg];

    // slot storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= item_in;
        end
    end

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

// ----- hdl/cca_back.sv -----
// back end: bitmap scan, peer grant and counter update, result word
module cca_back import cca_pkg::*; #(
    parameter int NUM_CHUNKS  = 64,
    parameter int NUM_PEERS   = 8,
    parameter int CHUNK_SHIFT = 21,
    parameter int CNW         = 7
) (
    input  logic              clk,
    input  logic              rst_n,
    input  cfg_t              cfg,
    input  logic [CNW-1:0]    n_chunks,
    input  logic              q_valid,
    input  item_t             q_item,
    output logic              q_pop,
    output logic              done,
    output logic [2:0]        status,
    output logic [PEER_W-1:0] granted_peer,
    output logic [OFF_W-1:0]  grant_offset,
    output logic [LEN_W-1:0]  grant_length,
    output logic [CNT_W-1:0]  active_connections,
    output logic              segment_complete
);

    localparam int NW   = (NUM_CHUNKS + ROW_W - 1) / ROW_W;
    localparam int RPW  = (NW > 1) ? $clog2(NW) : 1;
    localparam int XW   = RPW + ROW_BW;
    localparam int PW   = (NUM_PEERS > 1) ? $clog2(NUM_PEERS) : 1;
    localparam int NPW  = ($clog2(NUM_PEERS + 1) > PCNT_W) ? $clog2(NUM_PEERS + 1) : PCNT_W;
    localparam logic [OFF_W-1:0] CSZ = OFF_W'(64'd1 << CHUNK_SHIFT);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_UPD   = 4'b0010,
        S_SCAN  = 4'b0100,
        S_GRANT = 4'b1000
    } state_t;

    state_t            state_reg, state_next;
    item_t             item_reg;
    status_t           stat_reg, stat_next;

    logic [ROW_W-1:0]  acq_rows_reg  [NW];
    logic [ROW_W-1:0]  comm_rows_reg [NW];
    logic [RPW-1:0]    row_ptr_reg, row_ptr_next;

    logic              found_reg;
    logic [RPW-1:0]    frow_reg;
    logic [ROW_BW-1:0] fbit_reg;
    logic [ROW_W-1:0]  facq_reg;
    logic              uncomm_reg;

    logic [CNT_W-1:0]  pcnt_reg [NUM_PEERS];
    logic [CNT_W-1:0]  total_reg;

    logic              done_reg;
    status_t           out_status_reg;
    logic [PEER_W-1:0] out_peer_reg;
    logic [OFF_W-1:0]  out_off_reg;
    logic [LEN_W-1:0]  out_len_reg;
    logic [CNT_W-1:0]  out_active_reg;
    logic              out_complete_reg;

    logic [ROW_W-1:0]  acq_rd, comm_rd;
    logic [ROW_W-1:0]  in_rng, free_bits;
    logic              row_uncomm;
    logic              ff_hit;
    logic [ROW_BW-1:0] ff_bit;
    logic              last_row;
    logic [XW-1:0]     q_idx_x, upd_idx_x;
    logic [ROW_W-1:0]  upd_mask, grant_mask;

    logic [NPW-1:0]        np;
    logic [NUM_PEERS-1:0]  ulim, nz;
    logic [PEER_SPACE-1:0] ulim8, nz8;
    logic                  lo_hit;
    logic [PW-1:0]         lo_idx;
    logic                  want_ok, global_ok, grant_ok, rel_ok;
    logic [PW-1:0]         gpeer;

    logic [XW-1:0]     pos;
    logic [OFF_W-1:0]  start_b, goff, rem;
    logic [LEN_W-1:0]  glen;
    logic              emit_scan, emit_grant;

    // current bitmap row
    assign acq_rd  = acq_rows_reg[row_ptr_reg];
    assign comm_rd = comm_rows_reg[row_ptr_reg];
    assign last_row = row_ptr_reg == RPW'(NW - 1);

    // chunks of this row that lie inside the segment
    always_comb
    begin
        for (int b = 0; b < ROW_W; b++)
        begin
            in_rng[b] = {1'b0, row_ptr_reg, ROW_BW'(b)} < (XW + 1)'(n_chunks);
        end
    end

    assign free_bits  = ~acq_rd & ~comm_rd & in_rng;
    assign row_uncomm = |(~comm_rd & in_rng);

    // lowest free chunk in the row
    always_comb
    begin
        ff_hit = 1'b0;
        ff_bit = '0;
        for (int b = ROW_W - 1; b >= 0; b--)
        begin
            if (free_bits[b])
            begin
                ff_hit = 1'b1;
                ff_bit = ROW_BW'(b);
            end
        end
    end

    // chunk index split into row and bit
    assign q_idx_x    = XW'(q_item.idx);
    assign upd_idx_x  = XW'(item_reg.idx);
    assign upd_mask   = ROW_W'(1) << upd_idx_x[ROW_BW-1:0];
    assign grant_mask = ROW_W'(1) << fbit_reg;

    // peers in use and per-peer limit flags
    assign np = (NPW'(cfg.peer_count) >= NPW'(NUM_PEERS)) ? NPW'(NUM_PEERS)
                                                           : NPW'(cfg.peer_count);

    for (genvar p = 0; p < NUM_PEERS; p++)
    begin : g_peer_flags
        assign ulim[p] = (NPW'(p) < np) && (pcnt_reg[p] < cfg.max_per_peer);
        assign nz[p]   = pcnt_reg[p] != '0;
    end

    for (genvar q = 0; q < PEER_SPACE; q++)
    begin : g_peer_port
        if (q < NUM_PEERS)
        begin : g_real
            assign ulim8[q] = ulim[q];
            assign nz8[q]   = nz[q];
        end
        else
        begin : g_none
            assign ulim8[q] = 1'b0;
            assign nz8[q]   = 1'b0;
        end
    end

    // lowest peer under its limit
    always_comb
    begin
        lo_hit = 1'b0;
        lo_idx = '0;
        for (int p = NUM_PEERS - 1; p >= 0; p--)
        begin
            if (ulim[p])
            begin
                lo_hit = 1'b1;
                lo_idx = PW'(p);
            end
        end
    end

    // grant decision
    assign want_ok   = ulim8[item_reg.peer];
    assign global_ok = total_reg < cfg.conn_limit;
    assign grant_ok  = found_reg && global_ok && (want_ok || lo_hit);
    assign gpeer     = want_ok ? PW'(item_reg.peer) : lo_idx;
    assign rel_ok    = nz8[q_item.peer] && (total_reg != '0);

    // offset and length of the granted chunk
    assign pos     = {frow_reg, fbit_reg};
    assign start_b = OFF_W'(pos) << CHUNK_SHIFT;
    assign goff    = cfg.seg_base + start_b;
    assign rem     = OFF_W'(cfg.seg_bytes) - start_b;
    assign glen    = LEN_W'((rem < CSZ) ? rem : CSZ);

    assign q_pop      = (state_reg == S_IDLE) && q_valid;
    assign emit_scan  = (state_reg == S_SCAN) && last_row && (item_reg.cmd != CMD_GET);
    assign emit_grant = state_reg == S_GRANT;

    // sequencer next state, status and row pointer
    always_comb
    begin
        state_next   = state_reg;
        stat_next    = stat_reg;
        row_ptr_next = row_ptr_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    state_next   = S_SCAN;
                    stat_next    = ST_OK;
                    row_ptr_next = '0;
                    case (q_item.cmd)
                        CMD_PUT, CMD_ABORT:
                        begin
                            if (q_item.bad_off)
                            begin
                                stat_next = ST_BAD_OFFSET;
                            end
                            else if (!rel_ok)
                            begin
                                stat_next = ST_PEER_IDLE;
                            end
                            else
                            begin
                                state_next   = S_UPD;
                                row_ptr_next = q_idx_x[XW-1:ROW_BW];
                            end
                        end
                        default:
                        begin
                            stat_next = ST_OK;
                        end
                    endcase
                end
            end
            S_UPD:
            begin
                state_next   = S_SCAN;
                row_ptr_next = '0;
            end
            S_SCAN:
            begin
                if (last_row)
                begin
                    state_next = (item_reg.cmd == CMD_GET) ? S_GRANT : S_IDLE;
                end
                else
                begin
                    row_ptr_next = row_ptr_reg + RPW'(1);
                end
            end
            S_GRANT:
            begin
                state_next = S_IDLE;
                if (!found_reg)
                begin
                    stat_next = ST_NO_CHUNK;
                end
                else if (!grant_ok)
                begin
                    stat_next = ST_NO_PEER;
                end
                else
                begin
                    stat_next = ST_OK;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // sequencer registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            stat_reg    <= ST_OK;
            row_ptr_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            stat_reg    <= stat_next;
            row_ptr_reg <= row_ptr_next;
        end
    end

    // working word and scan results
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            item_reg   <= q_item;
            found_reg  <= 1'b0;
            uncomm_reg <= 1'b0;
        end
        else if (state_reg == S_SCAN)
        begin
            uncomm_reg <= uncomm_reg | row_uncomm;
            if (!found_reg && ff_hit)
            begin
                found_reg <= 1'b1;
                frow_reg  <= row_ptr_reg;
                fbit_reg  <= ff_bit;
                facq_reg  <= acq_rd;
            end
        end
    end

    // acquired and committed bitmaps
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < NW; r++)
            begin
                acq_rows_reg[r]  <= '0;
                comm_rows_reg[r] <= '0;
            end
        end
        else if (q_pop && (q_item.cmd == CMD_BEGIN))
        begin
            for (int r = 0; r < NW; r++)
            begin
                acq_rows_reg[r]  <= '0;
                comm_rows_reg[r] <= '0;
            end
        end
        else if (state_reg == S_UPD)
        begin
            acq_rows_reg[row_ptr_reg] <= acq_rd & ~upd_mask;
            if (item_reg.cmd == CMD_PUT)
            begin
                comm_rows_reg[row_ptr_reg] <= comm_rd | upd_mask;
            end
        end
        else if ((state_reg == S_GRANT) && grant_ok)
        begin
            acq_rows_reg[frow_reg] <= facq_reg | grant_mask;
        end
    end

    // per-peer busy counters
    for (genvar p = 0; p < NUM_PEERS; p++)
    begin : g_pcnt
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                pcnt_reg[p] <= '0;
            end
            else if ((state_reg == S_GRANT) && grant_ok && (gpeer == PW'(p)))
            begin
                pcnt_reg[p] <= pcnt_reg[p] + CNT_W'(1);
            end
            else if ((state_reg == S_UPD) && (int'(item_reg.peer) == p))
            begin
                pcnt_reg[p] <= pcnt_reg[p] - CNT_W'(1);
            end
        end
    end

    // total busy counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg <= '0;
        end
        else if ((state_reg == S_GRANT) && grant_ok)
        begin
            total_reg <= total_reg + CNT_W'(1);
        end
        else if (state_reg == S_UPD)
        begin
            total_reg <= total_reg - CNT_W'(1);
        end
    end

    // result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= emit_scan || emit_grant;
        end
    end

    // result word
    always_ff @(posedge clk)
    begin
        if (emit_scan)
        begin
            out_status_reg   <= stat_reg;
            out_peer_reg     <= '0;
            out_off_reg      <= '0;
            out_len_reg      <= '0;
            out_active_reg   <= total_reg;
            out_complete_reg <= !(uncomm_reg || row_uncomm);
        end
        else if (emit_grant)
        begin
            out_status_reg   <= stat_next;
            out_peer_reg     <= grant_ok ? PEER_W'(gpeer) : '0;
            out_off_reg      <= grant_ok ? goff : '0;
            out_len_reg      <= grant_ok ? glen : '0;
            out_active_reg   <= total_reg + CNT_W'(grant_ok);
            out_complete_reg <= !uncomm_reg;
        end
    end

    assign done               = done_reg;
    assign status             = out_status_reg;
    assign granted_peer       = out_peer_reg;
    assign grant_offset       = out_off_reg;
    assign grant_length       = out_len_reg;
    assign active_connections = out_active_reg;
    assign segment_complete   = out_complete_reg;

endmodule

// ----- hdl/chunk_and_connection_allocator_unit.sv -----
// top level of the chunk and connection allocator: register file and block wiring
//
//  channel   direction  handshake                      payload
//  command   in         start high, busy low           cmd, peer, chunk_offset
//  result    out        done high for one cycle        status, granted_peer, grant_offset,
//                                                      grant_length, active_connections,
//                                                      segment_complete
//  config    in         apb, write on psel, penable,   paddr, pwdata, prdata
//                       pwrite and pready
//
//  a get scans the NW 64-chunk bitmap rows of the back end (one row scanned per cycle)
//  and then grants; a valid put/abort updates bitmaps and counters before its scan;
//  begin and failed put/abort only scan; done follows in the cycle after the last step
//  two command words queue ahead of the back end; busy is high while the queue is full
//  rst_n clears bitmaps, counters, queue and registers to their reset values
//  results cannot be held off by the receiver
`include "assert_macros.svh"

module chunk_and_connection_allocator_unit import cca_pkg::*; #(
    parameter int NUM_CHUNKS  = 64,
    parameter int NUM_PEERS   = 8,
    parameter int CHUNK_SHIFT = 21
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [1:0]        cmd,
    input  logic [PEER_W-1:0] peer,
    input  logic [OFF_W-1:0]  chunk_offset,
    output logic              done,
    output logic [2:0]        status,
    output logic [PEER_W-1:0] granted_peer,
    output logic [OFF_W-1:0]  grant_offset,
    output logic [LEN_W-1:0]  grant_length,
    output logic [CNT_W-1:0]  active_connections,
    output logic              segment_complete,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    localparam int CNW = $clog2(NUM_CHUNKS + 1);
    localparam logic [SEGB_W-1:0] LO_MASK =
        (CHUNK_SHIFT >= SEGB_W) ? '1 : SEGB_W'((64'd1 << CHUNK_SHIFT) - 64'd1);

    logic [CNT_W-1:0]  conn_limit_reg;
    logic [CNT_W-1:0]  max_peer_reg;
    logic [PCNT_W-1:0] peer_cnt_reg;
    logic [OFF_W-1:0]  seg_base_reg;
    logic [SEGB_W-1:0] seg_bytes_reg;

    reg_idx_t          reg_idx;
    logic              cfg_wr;
    cfg_t              cfg;

    logic [SEGB_W-1:0] seg_q;
    logic [SEGB_W:0]   n_raw;
    logic [CNW-1:0]    n_chunks;

    logic              push, q_pop, q_valid, q_full;
    item_t             push_item, head_item;

    logic              fail_word, grant_clear;

    // register access
    assign pready  = 1'b1;
    assign reg_idx = reg_idx_t'(paddr[ADDR_W-1:3]);
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            conn_limit_reg <= CNT_W'(16);
            max_peer_reg   <= CNT_W'(4);
            peer_cnt_reg   <= PCNT_W'(8);
            seg_base_reg   <= '0;
            seg_bytes_reg  <= SEGB_W'(134217728);
        end
        else if (cfg_wr)
        begin
            case (reg_idx)
                REG_MAX_CONN:  conn_limit_reg <= pwdata[CNT_W-1:0];
                REG_MAX_PEER:  max_peer_reg   <= pwdata[CNT_W-1:0];
                REG_PEER_CNT:  peer_cnt_reg   <= pwdata[PCNT_W-1:0];
                REG_SEG_BASE:  seg_base_reg   <= pwdata[OFF_W-1:0];
                REG_SEG_BYTES: seg_bytes_reg  <= pwdata[SEGB_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // register read back
    always_comb
    begin
        case (reg_idx)
            REG_MAX_CONN:  prdata = DATA_W'(conn_limit_reg);
            REG_MAX_PEER:  prdata = DATA_W'(max_peer_reg);
            REG_PEER_CNT:  prdata = DATA_W'(peer_cnt_reg);
            REG_SEG_BASE:  prdata = DATA_W'(seg_base_reg);
            REG_SEG_BYTES: prdata = DATA_W'(seg_bytes_reg);
            default:       prdata = '0;
        endcase
    end

    assign cfg.conn_limit   = conn_limit_reg;
    assign cfg.max_per_peer = max_peer_reg;
    assign cfg.peer_count   = peer_cnt_reg;
    assign cfg.seg_base     = seg_base_reg;
    assign cfg.seg_bytes    = seg_bytes_reg;

    // chunk count of the segment, rounded up and capped
    assign seg_q    = seg_bytes_reg >> CHUNK_SHIFT;
    assign n_raw    = {1'b0, seg_q} + (SEGB_W + 1)'(|(seg_bytes_reg & LO_MASK));
    assign n_chunks = (n_raw >= (SEGB_W + 1)'(NUM_CHUNKS)) ? CNW'(NUM_CHUNKS) : CNW'(n_raw);

    cca_front #(
        .CHUNK_SHIFT (CHUNK_SHIFT),
        .CNW         (CNW)
    ) u_front (
        .start        (start),
        .cmd          (cmd),
        .peer         (peer),
        .chunk_offset (chunk_offset),
        .seg_base     (seg_base_reg),
        .n_chunks     (n_chunks),
        .q_full       (q_full),
        .busy         (busy),
        .push         (push),
        .item         (push_item)
    );

    cca_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .item_in  (push_item),
        .pop      (q_pop),
        .item_out (head_item),
        .valid    (q_valid),
        .full     (q_full)
    );

    cca_back #(
        .NUM_CHUNKS  (NUM_CHUNKS),
        .NUM_PEERS   (NUM_PEERS),
        .CHUNK_SHIFT (CHUNK_SHIFT),
        .CNW         (CNW)
    ) u_back (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg                (cfg),
        .n_chunks           (n_chunks),
        .q_valid            (q_valid),
        .q_item             (head_item),
        .q_pop              (q_pop),
        .done               (done),
        .status             (status),
        .granted_peer       (granted_peer),
        .grant_offset       (grant_offset),
        .grant_length       (grant_length),
        .active_connections (active_connections),
        .segment_complete   (segment_complete)
    );

    // failed result word and empty grant fields
    assign fail_word   = done && (status != ST_OK);
    assign grant_clear = (grant_offset == '0) && (grant_length == '0) && (granted_peer == '0);

    // checks
    `CCA_ASSERT_NEXT(a_done_spacing, done, !done, "result strobe on two cycles in a row")
    `CCA_ASSERT_IMPL(a_fail_no_grant, fail_word, grant_clear, "failed word carries a grant")
    `CCA_ASSERT_NEXT(a_push_queued, push, q_valid, "accepted word not in the queue")

endmodule
